@@ rtl/core/hpa_pkg.sv @@
package hpa_pkg;

    localparam int NUM_HANDLES = 256;
    localparam int ID_W        = $clog2(NUM_HANDLES);
    localparam int CNT_W       = $clog2(NUM_HANDLES + 1);
    localparam int HANDLE_W    = 8;

    localparam logic [1:0] OP_ALLOC   = 2'd0;
    localparam logic [1:0] OP_RELEASE = 2'd1;
    localparam logic [1:0] OP_QUERY   = 2'd2;

    localparam logic [1:0] STATUS_OK           = 2'd0;
    localparam logic [1:0] STATUS_POOL_FULL    = 2'd1;
    localparam logic [1:0] STATUS_BEYOND_MARK  = 2'd2;
    localparam logic [1:0] STATUS_ALREADY_FREE = 2'd3;

    typedef struct packed {
        logic capture;
        logic execute;
    } hpa_cmd_t;

    typedef struct packed {
        logic stack_empty;
    } hpa_stat_t;

endpackage

@@ rtl/core/hpa_ctrl.sv @@
module hpa_ctrl
    import hpa_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    input  hpa_stat_t stat,
    output hpa_cmd_t  cmd,
    output logic      pop_en
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb
    begin
        state_next  = state_reg;
        cmd.capture = 1'b0;
        cmd.execute = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                cmd.execute = 1'b1;
                state_next  = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // launch the stack read only when there is something to pop
    assign pop_en = cmd.capture && !stat.stack_empty;
    assign busy   = (state_reg == ST_EXEC);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/core/hpa_datapath.sv @@
module hpa_datapath
    import hpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  hpa_cmd_t            cmd,
    input  logic                pop_en,
    output hpa_stat_t           stat,
    input  logic [1:0]          opcode,
    input  logic [HANDLE_W-1:0] handle,
    output logic                done,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [1:0]          status,
    output logic                live
);

    logic [ID_W-1:0]        free_stack [NUM_HANDLES];

    logic [CNT_W-1:0]       free_count_reg;
    logic [CNT_W-1:0]       free_count_next;
    logic [CNT_W-1:0]       high_water_reg;
    logic [CNT_W-1:0]       high_water_next;
    logic [NUM_HANDLES-1:0] live_map_reg;
    logic [NUM_HANDLES-1:0] live_map_next;
    logic                   done_reg;

    logic [1:0]             op_reg;
    logic [HANDLE_W-1:0]    handle_reg;
    logic [ID_W-1:0]        pop_data_reg;
    logic                   live_rd_reg;
    logic [HANDLE_W-1:0]    handle_out_reg;
    logic [1:0]             status_reg;
    logic                   live_reg;

    logic [HANDLE_W-1:0]    hout;
    logic [1:0]             status_c;
    logic                   live_c;
    logic                   push_en;
    logic [CNT_W-1:0]       pop_addr;
    logic [ID_W-1:0]        id_idx;
    logic                   in_range;
    logic                   id_live;

    assign stat.stack_empty = (free_count_reg == '0);
    assign pop_addr         = free_count_reg - CNT_W'(1);
    assign id_idx           = ID_W'(handle_reg);
    assign in_range         = (CNT_W'(handle_reg) < high_water_reg)
                              && (CNT_W'(handle_reg) < CNT_W'(NUM_HANDLES));
    assign id_live          = live_rd_reg;

    always_comb
    begin
        free_count_next = free_count_reg;
        high_water_next = high_water_reg;
        live_map_next   = live_map_reg;
        hout            = handle_reg;
        status_c        = STATUS_OK;
        live_c          = 1'b0;
        push_en         = 1'b0;
        unique case (op_reg)
            OP_ALLOC:
            begin
                if (!stat.stack_empty)
                begin
                    free_count_next             = pop_addr;
                    hout                        = HANDLE_W'(pop_data_reg);
                    live_map_next[pop_data_reg] = 1'b1;
                    live_c                      = 1'b1;
                end
                else if (high_water_reg < CNT_W'(NUM_HANDLES))
                begin
                    hout                                = HANDLE_W'(high_water_reg);
                    live_map_next[high_water_reg[ID_W-1:0]] = 1'b1;
                    high_water_next                     = high_water_reg + CNT_W'(1);
                    live_c                              = 1'b1;
                end
                else
                begin
                    hout     = '0;
                    status_c = STATUS_POOL_FULL;
                end
            end
            OP_RELEASE:
            begin
                if (!in_range)
                begin
                    status_c = STATUS_BEYOND_MARK;
                end
                else if (!id_live)
                begin
                    status_c = STATUS_ALREADY_FREE;
                end
                else
                begin
                    live_map_next[id_idx] = 1'b0;
                    if (free_count_reg < CNT_W'(NUM_HANDLES))
                    begin
                        push_en         = 1'b1;
                        free_count_next = free_count_reg + CNT_W'(1);
                    end
                end
            end
            default:
            begin
                // query, and the unused code behaves the same
                live_c = in_range && id_live;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.execute && push_en)
        begin
            free_stack[free_count_reg[ID_W-1:0]] <= id_idx;
        end
        if (pop_en)
        begin
            pop_data_reg <= free_stack[pop_addr[ID_W-1:0]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg      <= opcode;
            handle_reg  <= handle;
            // live map only changes on execute, so this read stays valid
            live_rd_reg <= live_map_reg[ID_W'(handle)];
        end
        if (cmd.execute)
        begin
            handle_out_reg <= hout;
            status_reg     <= status_c;
            live_reg       <= live_c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_count_reg <= '0;
            high_water_reg <= '0;
            live_map_reg   <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.execute;
            if (cmd.execute)
            begin
                free_count_reg <= free_count_next;
                high_water_reg <= high_water_next;
                live_map_reg   <= live_map_next;
            end
        end
    end

    assign done       = done_reg;
    assign handle_out = handle_out_reg;
    assign status     = status_reg;
    assign live       = live_reg;

endmodule

@@ rtl/core/handle_pool_allocator.sv @@
// The edge that accepts start registers the request and launches the free-stack and
// live-map reads; the execute state then commits state and registers the result and
// the done strobe. A new request is not accepted until the previous one has left the
// execute state, during which busy is high. The result port cannot be stalled; a new
// request may be accepted while the previous result is on the output. Reset clears the
// counters and live map at once.
module handle_pool_allocator
    import hpa_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          opcode,
    input  logic [HANDLE_W-1:0] handle,
    output logic                done,
    output logic [HANDLE_W-1:0] handle_out,
    output logic [1:0]          status,
    output logic                live
);

    hpa_cmd_t  cmd;
    hpa_stat_t stat;
    logic      pop_en;

    hpa_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .stat   (stat),
        .cmd    (cmd),
        .pop_en (pop_en)
    );

    hpa_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .pop_en     (pop_en),
        .stat       (stat),
        .opcode     (opcode),
        .handle     (handle),
        .done       (done),
        .handle_out (handle_out),
        .status     (status),
        .live       (live)
    );

endmodule

@@ rtl/core/hpa_checker.sv @@
module hpa_checker
    import hpa_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [HANDLE_W-1:0] handle_out,
    input logic [1:0]          status,
    input logic                live
);

    // every accepted request is followed by a result strobe
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##2 done)
        else $error("result strobe missing after accepted request");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_no_stray_done: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result strobe without a request in flight");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status == STATUS_POOL_FULL) |-> (handle_out == '0 && !live))
        else $error("pool-full result carries a handle or live flag");

    a_error_not_live: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != STATUS_OK) |-> !live)
        else $error("failed request reports a live id");

endmodule

bind handle_pool_allocator hpa_checker u_hpa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .done       (done),
    .handle_out (handle_out),
    .status     (status),
    .live       (live)
);
